// ===== sv/pcft_pkg.sv =====
`default_nettype none
package pcft_pkg;

    localparam int FLOW_ENTRIES_DEF = 256;
    localparam int SEQ_ENTRIES_DEF  = 1024;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
    localparam logic [7:0]  PROTO_TCP        = 8'd6;
    localparam logic [7:0]  PROTO_UDP        = 8'd17;
    localparam logic [3:0]  MIN_HEADER_WORDS = 4'd5;

    typedef enum logic [2:0] {
        V_NOT_IPV4 = 3'd0,
        V_BAD_IP   = 3'd1,
        V_TCP      = 3'd2,
        V_BAD_TCP  = 3'd3,
        V_UDP      = 3'd4,
        V_OTHER    = 3'd5
    } t_verdict;

    typedef struct packed {
        logic [15:0] frame_type;
        logic [3:0]  ip_header_words;
        logic [7:0]  ip_protocol;
        logic [3:0]  tcp_offset_words;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [31:0] tcp_seq;
        logic [31:0] tcp_ack;
        logic [15:0] frame_length;
    } t_in_item;

    typedef struct packed {
        t_verdict    verdict;
        logic        is_retransmit;
        logic        new_flow;
        logic        flow_table_full;
        logic [8:0]  tcp_flow_total;
        logic [8:0]  udp_flow_total;
        logic [31:0] packets_seen;
        logic [31:0] tcp_packets_seen;
        logic [31:0] udp_packets_seen;
        logic [31:0] tcp_byte_total;
        logic [31:0] udp_byte_total;
    } t_out_item;

    // classified item handed from front to back
    typedef struct packed {
        t_verdict    verdict;
        logic [63:0] addr_key;
        logic [31:0] port_key;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] flen;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEQ,
        S_FLOW,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== sv/pcft_front.sv =====
`default_nettype none
module pcft_front (
    input  wire pcft_pkg::t_in_item i_item,
    output pcft_pkg::t_work         o_work
);
    import pcft_pkg::*;

    t_verdict verdict;

    // header checks in priority order
    always_comb begin
        if (i_item.frame_type != ETHERTYPE_IPV4) begin
            verdict = V_NOT_IPV4;
        end else if (i_item.ip_header_words < MIN_HEADER_WORDS) begin
            verdict = V_BAD_IP;
        end else if (i_item.ip_protocol == PROTO_TCP) begin
            verdict = (i_item.tcp_offset_words < MIN_HEADER_WORDS) ? V_BAD_TCP : V_TCP;
        end else if (i_item.ip_protocol == PROTO_UDP) begin
            verdict = V_UDP;
        end else begin
            verdict = V_OTHER;
        end
    end

    assign o_work = '{
        verdict:  verdict,
        addr_key: {i_item.source_address, i_item.dest_address},
        port_key: {i_item.source_port, i_item.dest_port},
        seq:      i_item.tcp_seq,
        ack:      i_item.tcp_ack,
        flen:     i_item.frame_length
    };

endmodule
`default_nettype wire

// ===== sv/pcft_queue.sv =====
`default_nettype none
module pcft_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  wire pcft_pkg::t_work  i_work,
    input  wire                   i_pop,
    output pcft_pkg::t_work       o_work,
    output pcft_pkg::t_queue_status o_status
);
    import pcft_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_work            r_mem [QUEUE_DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    assign o_work         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule
`default_nettype wire

// ===== sv/pcft_back.sv =====
`default_nettype none
module pcft_back #(
    parameter int FLOW_ENTRIES = pcft_pkg::FLOW_ENTRIES_DEF,
    parameter int SEQ_ENTRIES  = pcft_pkg::SEQ_ENTRIES_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire pcft_pkg::t_work    i_work,
    input  wire pcft_pkg::t_queue_status i_qstat,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire                     i_stall,
    output pcft_pkg::t_out_item     o_result
);
    import pcft_pkg::*;

    localparam int FAW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int FCW = $clog2(FLOW_ENTRIES + 1);
    localparam int SAW = $clog2(SEQ_ENTRIES);
    localparam int SCW = $clog2(SEQ_ENTRIES + 1);
    localparam int IW  = (FCW > SCW) ? FCW : SCW;

    // memories
    logic [95:0]  r_tcp_mem [FLOW_ENTRIES];
    logic [95:0]  r_udp_mem [FLOW_ENTRIES];
    logic [31:0]  r_seq_mem [SEQ_ENTRIES];
    logic [95:0]  r_tcp_rd, r_udp_rd;
    logic [31:0]  r_seq_rd;

    t_state       r_state, n_state;
    t_work        r_item;
    logic [IW-1:0] r_rd_idx, r_ridx;
    logic         r_rvalid;
    logic [31:0]  r_prev;
    logic         r_retx, r_ins, r_full;

    logic [FCW-1:0] r_tcp_cnt, r_udp_cnt;
    logic [SCW-1:0] r_seq_cnt;
    logic [31:0]  r_total, r_tcp_pkts, r_udp_pkts, r_tcp_bytes, r_udp_bytes;
    logic         r_out_valid;
    t_out_item    r_out;

    // search control
    logic         is_tcp;
    logic [IW-1:0] n_search;
    logic         issue, seq_hit, seq_last, seq_done;
    logic [95:0]  flow_rd;
    logic         flow_hit, flow_last, flow_done;
    logic         load_out;
    logic [FCW-1:0] flow_cnt;

    assign is_tcp   = (r_item.verdict == V_TCP);
    assign flow_cnt = is_tcp ? r_tcp_cnt : r_udp_cnt;
    assign n_search = (r_state == S_SEQ) ? IW'(r_seq_cnt) : IW'(flow_cnt);
    assign issue    = (r_rd_idx < n_search);

    assign seq_hit  = r_rvalid && (r_ridx != '0) && (r_prev == r_item.seq)
                      && (r_item.ack < r_seq_rd);
    assign seq_last = r_rvalid && (r_ridx == n_search - 1'b1);
    assign seq_done = (n_search == '0) || seq_hit || seq_last;

    assign flow_rd   = is_tcp ? r_tcp_rd : r_udp_rd;
    assign flow_hit  = r_rvalid && (flow_rd == {r_item.addr_key, r_item.port_key});
    assign flow_last = r_rvalid && (r_ridx == n_search - 1'b1);
    assign flow_done = (n_search == '0) || flow_hit || flow_last;

    assign load_out = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    case (i_work.verdict)
                        V_TCP:   n_state = S_SEQ;
                        V_UDP:   n_state = S_FLOW;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SEQ:   if (seq_done) n_state = S_FLOW;
            S_FLOW:  if (flow_done) n_state = S_DONE;
            S_DONE:  if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop = (r_state == S_IDLE) && !i_qstat.empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // streaming reads and search bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid    <= 1'b0;
            r_rd_idx    <= '0;
            r_tcp_cnt   <= '0;
            r_udp_cnt   <= '0;
            r_seq_cnt   <= '0;
            r_total     <= '0;
            r_tcp_pkts  <= '0;
            r_udp_pkts  <= '0;
            r_tcp_bytes <= '0;
            r_udp_bytes <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output register handshake
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_rvalid <= 1'b0;
                    r_rd_idx <= '0;
                    if (o_pop) begin
                        r_item <= i_work;
                        r_retx <= 1'b0;
                        r_ins  <= 1'b0;
                        r_full <= 1'b0;
                    end
                end
                S_SEQ, S_FLOW: begin
                    r_ridx <= r_rd_idx;
                    if (r_rvalid) begin
                        r_prev <= r_seq_rd;
                    end
                    if (r_state == S_SEQ && seq_done) begin
                        r_rvalid <= 1'b0;
                        r_rd_idx <= '0;
                        r_retx   <= seq_hit;
                        if (!seq_hit && r_seq_cnt < SCW'(SEQ_ENTRIES)) begin
                            r_seq_cnt <= r_seq_cnt + 1'b1;
                        end
                    end else begin
                        r_rvalid <= issue;
                        if (issue) begin
                            r_rd_idx <= r_rd_idx + 1'b1;
                        end
                    end
                    if (r_state == S_FLOW && flow_done && !flow_hit) begin
                        if (flow_cnt < FCW'(FLOW_ENTRIES)) begin
                            r_ins <= 1'b1;
                            if (is_tcp) r_tcp_cnt <= r_tcp_cnt + 1'b1;
                            else        r_udp_cnt <= r_udp_cnt + 1'b1;
                        end else begin
                            r_full <= 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_total     <= r_total + 1'b1;
                        if (is_tcp || r_item.verdict == V_BAD_TCP) begin
                            r_tcp_pkts <= r_tcp_pkts + 1'b1;
                        end
                        if (is_tcp) begin
                            r_tcp_bytes <= r_tcp_bytes + 32'(r_item.flen);
                        end
                        if (r_item.verdict == V_UDP) begin
                            r_udp_pkts  <= r_udp_pkts + 1'b1;
                            r_udp_bytes <= r_udp_bytes + 32'(r_item.flen);
                        end
                    end
                end
                default: begin
                    r_rvalid <= 1'b0;
                end
            endcase
        end
    end

    // result register, counters shown after this item
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.verdict          <= r_item.verdict;
            r_out.is_retransmit    <= r_retx;
            r_out.new_flow         <= r_ins;
            r_out.flow_table_full  <= r_full;
            r_out.tcp_flow_total   <= 9'(r_tcp_cnt);
            r_out.udp_flow_total   <= 9'(r_udp_cnt);
            r_out.packets_seen     <= r_total + 1'b1;
            r_out.tcp_packets_seen <= (is_tcp || r_item.verdict == V_BAD_TCP)
                                      ? r_tcp_pkts + 1'b1 : r_tcp_pkts;
            r_out.udp_packets_seen <= (r_item.verdict == V_UDP)
                                      ? r_udp_pkts + 1'b1 : r_udp_pkts;
            r_out.tcp_byte_total   <= is_tcp ? r_tcp_bytes + 32'(r_item.flen) : r_tcp_bytes;
            r_out.udp_byte_total   <= (r_item.verdict == V_UDP)
                                      ? r_udp_bytes + 32'(r_item.flen) : r_udp_bytes;
        end
    end

    // sequence history memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_SEQ && issue) begin
            r_seq_rd <= r_seq_mem[r_rd_idx[SAW-1:0]];
        end
        if (r_state == S_SEQ && seq_done && !seq_hit && r_seq_cnt < SCW'(SEQ_ENTRIES)) begin
            r_seq_mem[r_seq_cnt[SAW-1:0]] <= r_item.seq;
        end
    end

    // flow tables
    always_ff @(posedge i_clk) begin
        if (r_state == S_FLOW && issue) begin
            r_tcp_rd <= r_tcp_mem[r_rd_idx[FAW-1:0]];
        end
        if (r_state == S_FLOW && flow_done && !flow_hit && is_tcp
            && flow_cnt < FCW'(FLOW_ENTRIES)) begin
            r_tcp_mem[flow_cnt[FAW-1:0]] <= {r_item.addr_key, r_item.port_key};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FLOW && issue) begin
            r_udp_rd <= r_udp_mem[r_rd_idx[FAW-1:0]];
        end
        if (r_state == S_FLOW && flow_done && !flow_hit && !is_tcp
            && flow_cnt < FCW'(FLOW_ENTRIES)) begin
            r_udp_mem[flow_cnt[FAW-1:0]] <= {r_item.addr_key, r_item.port_key};
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule
`default_nettype wire

// ===== sv/packet_classifier_flow_tracker.sv =====
`default_nettype none
// Packet classifier and five-tuple flow tracker.
// Input channel: i_valid / o_stall carry one parsed frame header per item
// (i_item). Output channel: o_valid / i_stall carry one result per item
// (o_result): verdict, retransmission and flow flags, and running counters.
// A front stage classifies each item and writes it into a two-entry queue,
// so items keep being taken while the back end searches or a result waits.
// The back end walks the sequence history (valid TCP only) and then the
// protocol's flow table, one stored entry per cycle through registered
// memory reads. The history holds up to SEQ_ENTRIES recorded sequence
// numbers and each flow table up to FLOW_ENTRIES flows; UDP items walk
// only their flow table and any other item skips both. The back end takes
// one item at a time, so the history walk sets the rate for TCP.
// Reset clears all counters, the queue and the output valid flag; the stores
// need no clearing since only entries below their fill count are read.
// While i_stall is high the result holds and the back end waits; the queue
// fills and then o_stall rises.
module packet_classifier_flow_tracker #(
    parameter int FLOW_ENTRIES = pcft_pkg::FLOW_ENTRIES_DEF,
    parameter int SEQ_ENTRIES  = pcft_pkg::SEQ_ENTRIES_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_stall,
    input  wire pcft_pkg::t_in_item  i_item,
    output logic                     o_valid,
    input  wire                      i_stall,
    output pcft_pkg::t_out_item      o_result
);
    import pcft_pkg::*;

    t_work         front_work, head_work;
    t_queue_status qstat;
    logic          push, pop;

    pcft_front u_front (
        .i_item (i_item),
        .o_work (front_work)
    );

    assign o_stall = qstat.full;
    assign push    = i_valid && !qstat.full;

    pcft_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_work   (front_work),
        .i_pop    (pop),
        .o_work   (head_work),
        .o_status (qstat)
    );

    pcft_back #(
        .FLOW_ENTRIES (FLOW_ENTRIES),
        .SEQ_ENTRIES  (SEQ_ENTRIES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_work   (head_work),
        .i_qstat  (qstat),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    // queue can never be both full and empty
    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue full and empty");

    // a pop needs a stored item
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

    // retransmission only for valid TCP
    a_retx_tcp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.is_retransmit) |-> (o_result.verdict == V_TCP))
        else $error("retransmit flag on non-TCP item");

    // insert and table-full are exclusive, and only for flow protocols
    a_flow_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.new_flow || o_result.flow_table_full)) |->
        (!(o_result.new_flow && o_result.flow_table_full) &&
         (o_result.verdict == V_TCP || o_result.verdict == V_UDP)))
        else $error("bad flow flags");

endmodule
`default_nettype wire

// ===== tb/tb_packet_classifier_flow_tracker.sv =====
module tb_packet_classifier_flow_tracker;
    import pcft_pkg::*;

    localparam int FLOWS      = FLOW_ENTRIES_DEF;
    localparam int SEQS       = SEQ_ENTRIES_DEF;
    localparam int RAND_ITEMS = 560;
    localparam int STALL_LIMIT = 40000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_result;

    packet_classifier_flow_tracker u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_result(o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state: index 0 is the TCP table, 1 the UDP table
    logic [63:0] flow_addr_tab [2][FLOWS];
    logic [31:0] flow_port_tab [2][FLOWS];
    int          flow_fill [2];
    logic [31:0] seq_log [SEQS];
    int          seq_fill;
    logic [31:0] frame_cnt, tcp_cnt, udp_cnt, tcp_byte_sum, udp_byte_sum;

    t_out_item result_fifo [$];
    int        errors = 0;
    int        send_idle = 0;
    int        recv_idle = 0;

    // pools of keys and sequence numbers already sent, for repeats
    logic [95:0] used_keys [2][$];
    logic [31:0] used_seqs [$];

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // look up a five-tuple; store it when absent and the table has room
    function automatic void flow_update(int p, logic [63:0] a, logic [31:0] k,
                                        ref t_out_item r);
        for (int i = 0; i < flow_fill[p]; i++)
            if (flow_addr_tab[p][i] == a && flow_port_tab[p][i] == k) return;
        if (flow_fill[p] < FLOWS) begin
            flow_addr_tab[p][flow_fill[p]] = a;
            flow_port_tab[p][flow_fill[p]] = k;
            flow_fill[p]++;
            r.new_flow = 1'b1;
        end else begin
            r.flow_table_full = 1'b1;
        end
    endfunction

    function automatic t_out_item classify_frame(t_in_item it);
        t_out_item   r;
        logic [63:0] a;
        logic [31:0] k;
        r = '0;
        a = {it.source_address, it.dest_address};
        k = {it.source_port, it.dest_port};
        frame_cnt++;
        if (it.frame_type != ETHERTYPE_IPV4) begin
            r.verdict = V_NOT_IPV4;
        end else if (it.ip_header_words < MIN_HEADER_WORDS) begin
            r.verdict = V_BAD_IP;
        end else if (it.ip_protocol == PROTO_TCP) begin
            tcp_cnt++;
            if (it.tcp_offset_words < MIN_HEADER_WORDS) begin
                r.verdict = V_BAD_TCP;
            end else begin
                r.verdict = V_TCP;
                for (int i = 0; i + 1 < seq_fill; i++)
                    if (seq_log[i] == it.tcp_seq && it.tcp_ack < seq_log[i+1]) begin
                        r.is_retransmit = 1'b1;
                        break;
                    end
                if (!r.is_retransmit && seq_fill < SEQS) begin
                    seq_log[seq_fill] = it.tcp_seq;
                    seq_fill++;
                end
                flow_update(0, a, k, r);
                tcp_byte_sum += 32'(it.frame_length);
            end
        end else if (it.ip_protocol == PROTO_UDP) begin
            r.verdict = V_UDP;
            udp_cnt++;
            flow_update(1, a, k, r);
            udp_byte_sum += 32'(it.frame_length);
        end else begin
            r.verdict = V_OTHER;
        end
        r.tcp_flow_total   = flow_fill[0][8:0];
        r.udp_flow_total   = flow_fill[1][8:0];
        r.packets_seen     = frame_cnt;
        r.tcp_packets_seen = tcp_cnt;
        r.udp_packets_seen = udp_cnt;
        r.tcp_byte_total   = tcp_byte_sum;
        r.udp_byte_total   = udp_byte_sum;
        return r;
    endfunction

    // hand one item to the block, then record what it should return
    task automatic send_frame(t_in_item it, bit typed, t_out_item typed_res);
        t_out_item r;
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
        r = classify_frame(it);
        result_fifo.push_back(typed ? typed_res : r);
        if (it.ip_protocol == PROTO_TCP) used_seqs.push_back(it.tcp_seq);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (result_fifo.size() != 0) @(negedge i_clk);
    endtask

    // random frame: mostly well-formed UDP/TCP, some noise
    function automatic t_in_item random_frame();
        t_in_item     it;
        logic [223:0] raw;
        int           kind;
        int           p;
        logic [95:0]  key;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        kind = int'($urandom_range(99));
        it.frame_type = ETHERTYPE_IPV4;
        it.ip_header_words = 4'($urandom_range(15, 5));
        it.tcp_offset_words = 4'($urandom_range(15, 5));
        if (kind < 55) it.ip_protocol = PROTO_UDP;
        else if (kind < 85) it.ip_protocol = PROTO_TCP;
        else if (kind < 90) it.frame_type = 16'($urandom);
        else if (kind < 94) it.ip_header_words = 4'($urandom_range(4, 0));
        else if (kind < 97) begin
            it.ip_protocol = PROTO_TCP;
            it.tcp_offset_words = 4'($urandom_range(4, 0));
        end
        p = (it.ip_protocol == PROTO_TCP) ? 0 : 1;
        if (used_keys[p].size() != 0 && $urandom_range(99) < 12) begin
            key = used_keys[p][$urandom_range(used_keys[p].size() - 1)];
            {it.source_address, it.dest_address, it.source_port, it.dest_port} = key;
        end else begin
            used_keys[p].push_back({it.source_address, it.dest_address,
                                    it.source_port, it.dest_port});
        end
        if (p == 0 && used_seqs.size() != 0 && $urandom_range(99) < 45)
            it.tcp_seq = used_seqs[$urandom_range(used_seqs.size() - 1)];
        return it;
    endfunction

    // directed rows: item, whether the result is typed in, typed result
    typedef struct {
        t_in_item  it;
        bit        typed;
        t_out_item res;
    } t_row;

    function automatic t_in_item mk(logic [15:0] et, logic [3:0] ipw, logic [7:0] pr,
                                    logic [3:0] tw, logic [31:0] sq, logic [31:0] ak,
                                    logic [15:0] fl);
        t_in_item it;
        it = '0;
        it.frame_type = et; it.ip_header_words = ipw; it.ip_protocol = pr;
        it.tcp_offset_words = tw; it.tcp_seq = sq; it.tcp_ack = ak;
        it.frame_length = fl;
        it.source_address = 32'h0a000001; it.dest_address = 32'h0a000002;
        it.source_port = 16'd1000; it.dest_port = 16'd80;
        return it;
    endfunction

    // result check at the output handshake
    always @(posedge i_clk) begin
        t_out_item w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (result_fifo.size() == 0) begin
                report("unexpected result", o_result.packets_seen, '0);
            end else begin
                w = result_fifo.pop_front();
                if (o_result.verdict != w.verdict)
                    report("verdict", 32'(o_result.verdict), 32'(w.verdict));
                if (o_result.is_retransmit != w.is_retransmit)
                    report("is_retransmit", 32'(o_result.is_retransmit),
                           32'(w.is_retransmit));
                if (o_result.new_flow != w.new_flow)
                    report("new_flow", 32'(o_result.new_flow), 32'(w.new_flow));
                if (o_result.flow_table_full != w.flow_table_full)
                    report("flow_table_full", 32'(o_result.flow_table_full),
                           32'(w.flow_table_full));
                if (o_result.tcp_flow_total != w.tcp_flow_total)
                    report("tcp_flow_total", 32'(o_result.tcp_flow_total),
                           32'(w.tcp_flow_total));
                if (o_result.udp_flow_total != w.udp_flow_total)
                    report("udp_flow_total", 32'(o_result.udp_flow_total),
                           32'(w.udp_flow_total));
                if (o_result.packets_seen != w.packets_seen)
                    report("packets_seen", o_result.packets_seen, w.packets_seen);
                if (o_result.tcp_packets_seen != w.tcp_packets_seen)
                    report("tcp_packets_seen", o_result.tcp_packets_seen, w.tcp_packets_seen);
                if (o_result.udp_packets_seen != w.udp_packets_seen)
                    report("udp_packets_seen", o_result.udp_packets_seen, w.udp_packets_seen);
                if (o_result.tcp_byte_total != w.tcp_byte_total)
                    report("tcp_byte_total", o_result.tcp_byte_total, w.tcp_byte_total);
                if (o_result.udp_byte_total != w.udp_byte_total)
                    report("udp_byte_total", o_result.udp_byte_total, w.udp_byte_total);
            end
        end
    end

    // receiver stall
    always @(negedge i_clk) i_stall <= ($urandom_range(99) < recv_idle);

    // watchdog on cycles with no handshake on either side
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) quiet = 0;
            else quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        t_row      rows [$];
        t_row      row;
        t_out_item z;
        flow_fill = '{0, 0};
        seq_fill = 0;
        frame_cnt = 0; tcp_cnt = 0; udp_cnt = 0; tcp_byte_sum = 0; udp_byte_sum = 0;

        // after reset: drops move only the frame counter, bad TCP also the TCP packet counter
        z = '0; z.verdict = V_NOT_IPV4; z.packets_seen = 1;
        rows.push_back('{mk(16'h86dd, 4'd5, PROTO_TCP, 4'd5, '0, '0, 16'd100), 1'b1, z});
        z.verdict = V_NOT_IPV4; z.packets_seen = 2;
        rows.push_back('{mk(16'hffff, 4'hf, 8'hff, 4'hf, 32'hffffffff, 32'hffffffff,
                            16'hffff), 1'b1, z});
        z.verdict = V_BAD_IP; z.packets_seen = 3;
        rows.push_back('{mk(ETHERTYPE_IPV4, 4'd0, PROTO_TCP, 4'd5, '0, '0, 16'd60), 1'b1, z});
        z.verdict = V_BAD_IP; z.packets_seen = 4;
        rows.push_back('{mk(ETHERTYPE_IPV4, 4'd4, PROTO_UDP, 4'd5, '0, '0, 16'd60), 1'b1, z});
        z.verdict = V_OTHER; z.packets_seen = 5;
        rows.push_back('{mk(ETHERTYPE_IPV4, 4'd5, 8'd1, 4'd5, '0, '0, 16'd60), 1'b1, z});
        z.verdict = V_BAD_TCP; z.packets_seen = 6; z.tcp_packets_seen = 1;
        rows.push_back('{mk(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd4, '0, '0, 16'd60), 1'b1, z});
        z.verdict = V_BAD_TCP; z.packets_seen = 7; z.tcp_packets_seen = 2;
        rows.push_back('{mk(ETHERTYPE_IPV4, 4'hf, PROTO_TCP, 4'd0, '0, '0, 16'd60), 1'b1, z});
        // TCP history: seq 100, 200, then 100 again with ack below 200 and at 200, then extreme values
        rows.push_back('{mk(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 32'd100, '0, '0),
                         1'b0, z});
        rows.push_back('{mk(ETHERTYPE_IPV4, 4'hf, PROTO_TCP, 4'hf, 32'd200, 32'd50,
                            16'hffff), 1'b0, z});
        rows.push_back('{mk(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 32'd100, 32'd199,
                            16'd40), 1'b0, z});
        rows.push_back('{mk(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 32'd100, 32'd200,
                            16'd40), 1'b0, z});
        rows.push_back('{mk(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 32'hffffffff, '0,
                            16'd40), 1'b0, z});
        rows.push_back('{mk(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, '0, 32'hffffffff,
                            16'd40), 1'b0, z});
        // UDP: new flow, same flow, all-ones key; then that key and an all-zero key as TCP
        rows.push_back('{mk(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 4'd0, '0, '0, 16'hffff),
                         1'b0, z});
        rows.push_back('{mk(ETHERTYPE_IPV4, 4'hf, PROTO_UDP, 4'hf, 32'd5, 32'd5, '0),
                         1'b0, z});
        row = '{mk(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 4'd5, '0, '0, 16'd10), 1'b0, z};
        row.it.source_address = 32'hffffffff; row.it.dest_address = 32'hffffffff;
        row.it.source_port = 16'hffff; row.it.dest_port = 16'hffff;
        rows.push_back(row);
        row.it.ip_protocol = PROTO_TCP;
        rows.push_back(row);
        row.it.source_address = '0; row.it.dest_address = '0;
        row.it.source_port = '0; row.it.dest_port = '0;
        rows.push_back(row);

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle = 7; recv_idle = 72;
        foreach (rows[i]) send_frame(rows[i].it, rows[i].typed, rows[i].res);
        for (int ph = 0; ph < 3; ph++) begin
            // hold off until the block has returned everything
            drain_results();
            if (ph == 1) begin send_idle = 72; recv_idle = 7; end
            if (ph == 2) begin send_idle = 0; recv_idle = 0; end
            for (int n = 0; n < RAND_ITEMS / 3; n++) send_frame(random_frame(), 1'b0, z);
        end
        drain_results();
        repeat (50) @(negedge i_clk);
        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule
